@@ design/deque_pkg.sv @@
// ----------------------------------------------------------------------------
// deque_pkg
// Command and status codes and fixed field widths of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deque_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FILL_WIDTH  = 9;

   typedef logic [2:0]             cmd_type;
   typedef logic [1:0]             status_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [FILL_WIDTH-1:0]  fill_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_POP_FRONT  = 3'd1;
   localparam cmd_type CMD_PUSH_BACK  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_PEEK_FRONT = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ design/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of DEPTH words: push/pop at both ends, peek at the front.
// ----------------------------------------------------------------------------
// Takes one item per clock when the result side keeps up. Each item gives one
// result: the accept cycle updates the indices, writes the ring memory for
// pushes and issues the memory read for pops and peeks; the registered read
// data is then turned into the result in the output register. Pops and peeks
// on an empty deque and pushes into a full one return -1 with an empty or full
// status and leave the deque as is. Unused command codes return -1 with status
// ok. No clearing pass after reset.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire deque_pkg::cmd_type   req_cmd,
   input  wire deque_pkg::value_type req_value,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output deque_pkg::value_type    rsp_read_value,
   output deque_pkg::status_type   rsp_status,
   output deque_pkg::fill_type     rsp_fill_count
);
   import deque_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      logic       use_read;
      status_type status;
      cnt_type    fill;
   } stage_type;

   word_type ring_mem [DEPTH];

   idx_type   front_ff, front_in;
   idx_type   back_ff, back_in;
   cnt_type   count_ff, count_in;
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   word_type  rd_data_ff;
   logic      rsp_valid_ff;
   value_type rsp_value_ff;
   status_type rsp_status_ff;
   fill_type  rsp_fill_ff;

   logic      accept;
   logic      advance;
   logic      mem_we;
   idx_type   mem_waddr;
   idx_type   mem_raddr;
   word_type  wr_word;
   idx_type   front_dec, back_inc, back_dec, front_inc;
   logic      is_empty, is_full;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0] wr_ext;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0] rd_ext;
   logic [CNT_W+FILL_WIDTH-1:0]       fill_ext;

   function automatic idx_type idx_inc(input idx_type i);
      return (i == IDX_LAST) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      return (i == '0) ? IDX_LAST : idx_type'(i - 1'b1);
   endfunction

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign front_dec = idx_dec(front_ff);
   assign front_inc = idx_inc(front_ff);
   assign back_dec  = idx_dec(back_ff);
   assign back_inc  = idx_inc(back_ff);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff >= CNT_FULL);

   assign wr_ext  = {{DATA_WIDTH{1'b0}}, req_value};
   assign wr_word = wr_ext[DATA_WIDTH-1:0];

   always_comb begin
      front_in       = front_ff;
      back_in        = back_ff;
      count_in       = count_ff;
      mem_we         = 1'b0;
      mem_waddr      = back_ff;
      mem_raddr      = front_ff;
      s1_in.use_read = 1'b0;
      s1_in.status   = ST_OK;
      case (req_cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (is_full) begin
               s1_in.status = ST_FULL;
            end else if (req_cmd == CMD_PUSH_FRONT) begin
               mem_we    = accept;
               mem_waddr = front_dec;
               front_in  = front_dec;
               count_in  = cnt_type'(count_ff + 1'b1);
            end else begin
               mem_we    = accept;
               mem_waddr = back_ff;
               back_in   = back_inc;
               count_in  = cnt_type'(count_ff + 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT: begin
            if (is_empty) begin
               s1_in.status = ST_EMPTY;
            end else if (req_cmd == CMD_POP_BACK) begin
               s1_in.use_read = 1'b1;
               mem_raddr      = back_dec;
               back_in        = back_dec;
               count_in       = cnt_type'(count_ff - 1'b1);
            end else begin
               s1_in.use_read = 1'b1;
               if (req_cmd == CMD_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = cnt_type'(count_ff - 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
      s1_in.fill = count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= wr_word;
      end
      if (accept) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   assign rd_ext   = {{VALUE_WIDTH{rd_data_ff[DATA_WIDTH-1]}}, rd_data_ff};
   assign fill_ext = {{FILL_WIDTH{1'b0}}, s1_ff.fill};

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            count_ff <= count_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         rsp_value_ff  <= s1_ff.use_read ? rd_ext[VALUE_WIDTH-1:0] : '1;
         rsp_status_ff <= s1_ff.status;
         rsp_fill_ff   <= fill_ext[FILL_WIDTH-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("element count above depth");

   a_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> front_ff == back_ff)
      else $error("indices apart on empty or full deque");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.status == ST_EMPTY) |-> s1_ff.fill == '0)
      else $error("empty status with nonzero fill");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (accept && is_full) |-> !mem_we)
      else $error("write into full ring");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_ff))
      else $error("pending item lost while stalled");

endmodule

`default_nettype wire
